// ===== rtl/core/rational_arithmetic_unit_core_defines.svh =====
// Assertion macros for the rational arithmetic core.
// Included by the core RTL files; compiled out when SYNTH is defined.
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`ifndef SYNTH
`define RAU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("rau assertion");
`define RAU_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("rau reset assertion");
`else
`define RAU_ASSERT(lbl, clk, rst_n, prop)
`define RAU_ASSERT_RST(lbl, clk, prop)
`endif
`endif

// ===== rtl/core/rau_pkg.sv =====
// Shared types and codes for the rational arithmetic core.
// No dependencies.
`default_nettype none
package rau_pkg;
  localparam int unsigned MAG_W = 64;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_CMP = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL1,
    BK_MUL2,
    BK_COMB,
    BK_GCD,
    BK_DIV,
    BK_DONE
  } bk_state_t;

  // classified item passed from the front end to the back end
  typedef struct packed {
    logic        direct;
    logic [1:0]  status;
    logic        is_equal;
    logic [2:0]  action;
    logic [31:0] an;
    logic [31:0] ad;
    logic [31:0] bn;
    logic [31:0] bd;
  } job_t;
endpackage
`default_nettype wire

// ===== rtl/core/rau_front.sv =====
// Front end: sign-extends operands, decodes the action and settles the
// trivial cases. Depends on rau_pkg.
`default_nettype none
module rau_front #(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [2:0]        in_action,
  input  logic [31:0]       in_a_num,
  input  logic [31:0]       in_a_den,
  input  logic [31:0]       in_b_num,
  input  logic [31:0]       in_b_den,
  output logic              q_push,
  input  logic              q_full,
  output rau_pkg::job_t     q_job
);
  import rau_pkg::*;

  logic        valid_r, valid_nxt;
  job_t        job_r, job_nxt;
  logic [31:0] an, ad, bn, bd;
  logic        accept;

  function automatic logic [31:0] sext(input logic [31:0] x);
    logic [31:0] r;
    r = x;
    for (int i = 0; i < 32; i++) begin
      if (i >= int'(WORD_WIDTH)) r[i] = x[WORD_WIDTH-1];
    end
    return r;
  endfunction

  assign an = sext(in_a_num);
  assign ad = sext(in_a_den);
  assign bn = sext(in_b_num);
  assign bd = sext(in_b_den);

  assign in_full = valid_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_push  = valid_r;
  assign q_job   = job_r;

  always_comb begin
    job_nxt          = job_r;
    valid_nxt        = valid_r;
    if (valid_r && !q_full) valid_nxt = 1'b0;
    if (accept) begin
      valid_nxt       = 1'b1;
      job_nxt.action  = in_action;
      job_nxt.an      = an;
      job_nxt.ad      = ad;
      job_nxt.bn      = bn;
      job_nxt.bd      = bd;
      job_nxt.is_equal = 1'b0;
      job_nxt.status  = ST_OK;
      job_nxt.direct  = 1'b0;
      if (in_action > ACT_CMP) begin
        job_nxt.direct = 1'b1;
      end else if (ad == '0 || bd == '0) begin
        job_nxt.direct = 1'b1;
        job_nxt.status = ST_ZERO_DEN;
      end else if (in_action == ACT_DIV && bn == '0) begin
        job_nxt.direct = 1'b1;
        job_nxt.status = ST_ZERO_DEN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
    job_r <= job_nxt;
  end
endmodule
`default_nettype wire

// ===== rtl/core/rau_queue.sv =====
// Two-entry item queue between front and back ends.
// Depends on rau_pkg.
`default_nettype none
module rau_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  rau_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd_en,
  output logic          rd_valid,
  output rau_pkg::job_t rd_job
);
  import rau_pkg::*;
  `include "rational_arithmetic_unit_core_defines.svh"

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_wr, do_rd;

  assign full     = cnt_r == 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_job   = mem_r[rp_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) wp_r <= ~wp_r;
      if (do_rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
    if (do_wr) mem_r[wp_r] <= wr_job;
  end

  `RAU_ASSERT(a_q_cnt, clk, rst_n, cnt_r <= 2'd2)
  `RAU_ASSERT(a_q_ptr, clk, rst_n, (cnt_r == 2'd1) |-> (wp_r != rp_r))
  `RAU_ASSERT(a_q_ptr2, clk, rst_n, (cnt_r != 2'd1) |-> (wp_r == rp_r))
endmodule
`default_nettype wire

// ===== rtl/core/rau_back.sv =====
// Back end: cross products, sum, Euclidean gcd and exact division by
// shared shift-subtract unit, range check. Depends on rau_pkg.
`default_nettype none
module rau_back #(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  rau_pkg::job_t     q_job,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [31:0]       out_res_num,
  output logic [30:0]       out_res_den,
  output logic              out_is_equal,
  output logic [1:0]        out_status
);
  import rau_pkg::*;
  `include "rational_arithmetic_unit_core_defines.svh"

  bk_state_t   st_r, st_nxt;
  job_t        job_r;
  logic signed [63:0] p0_r, p1_r, p2_r;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic        nneg_r, dneg_r;
  logic [63:0] nm_r, dm_r;
  logic [63:0] x_r, y_r;
  logic [63:0] rem_r, quo_r, dvd_r;
  logic [6:0]  bit_r;
  logic        dsel_r;
  logic        res_v_r;
  logic [31:0] rnum_r;
  logic [30:0] rden_r;
  logic        req_r;
  logic [1:0]  rst_s_r;
  logic [63:0] rem_sh, lim;
  logic [64:0] diff;
  logic        neg_p, neg_q;
  logic [63:0] mp, mq;
  logic [63:0] dm_c;
  logic        fin_neg;

  assign ma   = (st_r == BK_IDLE || st_r == BK_MUL1) ? (st_r == BK_IDLE ? q_job.an : job_r.ad)
                : job_r.ad;
  assign mb   = (st_r == BK_IDLE) ? ((q_job.action == ACT_MUL) ? q_job.bn : q_job.bd)
                : (st_r == BK_MUL1) ? job_r.bn
                : job_r.bd;
  assign prod = ma * mb;
  assign lim  = 64'd1 << (WORD_WIDTH - 1);

  assign rem_sh = {rem_r[62:0], dvd_r[63]};
  assign diff   = {1'b0, rem_sh} - {1'b0, y_r};
  assign neg_p  = p0_r[63];
  assign neg_q  = (job_r.action == ACT_SUB) ? !p1_r[63] && p1_r != '0 : p1_r[63];
  assign mp     = p0_r[63] ? 64'd0 - p0_r : p0_r;
  assign mq     = p1_r[63] ? 64'd0 - p1_r : p1_r;
  assign dm_c   = (job_r.action == ACT_DIV) ? mq : (p2_r[63] ? 64'd0 - p2_r : p2_r);
  assign fin_neg = nneg_r != dneg_r;

  assign q_pop        = (st_r == BK_IDLE) && q_valid && !res_v_r;
  assign out_empty    = !res_v_r;
  assign out_res_num  = rnum_r;
  assign out_res_den  = rden_r;
  assign out_is_equal = req_r;
  assign out_status   = rst_s_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: if (q_pop) st_nxt = q_job.direct ? BK_IDLE : BK_MUL1;
      BK_MUL1: st_nxt = BK_MUL2;
      BK_MUL2: st_nxt = (job_r.action == ACT_CMP) ? BK_DONE : BK_COMB;
      BK_COMB: st_nxt = (dm_c == '0 || nm_r == '0) ? BK_IDLE : BK_GCD;
      BK_GCD:  if (y_r == '0 && bit_r == '0) st_nxt = BK_DIV;
      BK_DIV:  if (bit_r == 7'd64 && dsel_r) st_nxt = BK_DONE;
      BK_DONE: st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= BK_IDLE;
      res_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_pop && res_v_r) res_v_r <= 1'b0;
      if (st_r == BK_IDLE && q_pop && q_job.direct) res_v_r <= 1'b1;
      if (st_r == BK_DONE) res_v_r <= 1'b1;
      if (st_r == BK_COMB && (dm_c == '0 || nm_r == '0)) res_v_r <= 1'b1;
    end
    case (st_r)
      BK_IDLE: begin
        if (q_pop) begin
          job_r   <= q_job;
          p0_r    <= prod;
          rnum_r  <= '0;
          rden_r  <= 31'd1;
          req_r   <= 1'b0;
          rst_s_r <= q_job.status;
        end
      end
      BK_MUL1: p1_r <= prod;
      BK_MUL2: begin
        p2_r <= prod;
        if (job_r.action == ACT_CMP) req_r <= (p0_r == p1_r);
        // numerator magnitude and sign
        if (job_r.action == ACT_MUL || job_r.action == ACT_DIV) begin
          nneg_r <= p0_r[63];
          nm_r   <= mp;
        end else if (neg_p == neg_q) begin
          nneg_r <= neg_p;
          nm_r   <= mp + mq;
        end else if (mp >= mq) begin
          nneg_r <= neg_p;
          nm_r   <= mp - mq;
        end else begin
          nneg_r <= neg_q;
          nm_r   <= mq - mp;
        end
      end
      BK_COMB: begin
        if (job_r.action == ACT_DIV) begin
          dneg_r <= p1_r[63];
          dm_r   <= mq;
          x_r    <= nm_r;
          y_r    <= mq;
        end else begin
          dneg_r <= p2_r[63];
          dm_r   <= p2_r[63] ? 64'd0 - p2_r : p2_r;
          x_r    <= nm_r;
          y_r    <= p2_r[63] ? 64'd0 - p2_r : p2_r;
        end
        bit_r <= '0;
        rem_r <= '0;
        dvd_r <= nm_r;
      end
      default: ;
    endcase
    if (st_r == BK_COMB && dm_c == '0) begin
      rst_s_r <= ST_ZERO_DEN;
    end
    if (st_r == BK_GCD) begin
      // one shift-subtract step of x mod y per cycle
      if (y_r != '0) begin
        if (bit_r == 7'd0) begin
          dvd_r <= x_r;
          rem_r <= '0;
          bit_r <= 7'd1;
        end else begin
          rem_r <= diff[64] ? rem_sh : diff[63:0];
          dvd_r <= {dvd_r[62:0], 1'b0};
          if (bit_r == 7'd64) begin
            x_r   <= y_r;
            y_r   <= diff[64] ? rem_sh : diff[63:0];
            bit_r <= 7'd0;
          end else begin
            bit_r <= bit_r + 7'd1;
          end
        end
      end else begin
        // x_r now holds the gcd; start nm / g
        y_r    <= x_r;
        dvd_r  <= nm_r;
        rem_r  <= '0;
        quo_r  <= '0;
        bit_r  <= '0;
        dsel_r <= 1'b0;
      end
    end
    if (st_r == BK_DIV) begin
      if (bit_r == 7'd64) begin
        if (!dsel_r) begin
          nm_r   <= quo_r;
          dvd_r  <= dm_r;
          rem_r  <= '0;
          quo_r  <= '0;
          bit_r  <= '0;
          dsel_r <= 1'b1;
        end else begin
          dm_r <= quo_r;
        end
      end else begin
        rem_r <= diff[64] ? rem_sh : diff[63:0];
        dvd_r <= {dvd_r[62:0], 1'b0};
        quo_r <= {quo_r[62:0], !diff[64]};
        bit_r <= bit_r + 7'd1;
      end
    end
    if (st_r == BK_DONE && job_r.action != ACT_CMP) begin
      if (dm_r > lim - 64'd1 || nm_r > (fin_neg ? lim : lim - 64'd1)) begin
        rst_s_r <= ST_OVERFLOW;
      end else begin
        rnum_r <= fin_neg ? 32'd0 - nm_r[31:0] : nm_r[31:0];
        rden_r <= dm_r[30:0];
      end
    end
  end

  `RAU_ASSERT(a_bk_pop_idle, clk, rst_n, q_pop |-> (st_r == BK_IDLE))
  `RAU_ASSERT(a_bk_den_ok, clk, rst_n,
    (!out_empty && out_status == ST_OK) |-> (out_res_den != '0))
  `RAU_ASSERT(a_bk_hold, clk, rst_n,
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_res_num)))
endmodule
`default_nettype wire

// ===== rtl/core/rational_arithmetic_unit_core.sv =====
// Channel   Ports                                   Handshake
// input     in_action, in_a_num/den, in_b_num/den   in_push / in_full
// result    out_res_num/den, out_is_equal, out_status out_pop / out_empty
// Trivial cases are settled by the front end; compare and zero numerator end before
// the divider; arithmetic runs the Euclid steps and then the two quotient divisions,
// all on one shared shift-subtract divider.
// Reset: synchronous, rst_n low. A two-entry queue decouples front and back.
// Back end takes a new item only once its result register is free.
// Depends on rau_pkg, rau_front, rau_queue, rau_back.
`default_nettype none
module rational_arithmetic_unit_core #(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_a_num,
  input  logic [31:0] in_a_den,
  input  logic [31:0] in_b_num,
  input  logic [31:0] in_b_den,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_res_num,
  output logic [30:0] out_res_den,
  output logic        out_is_equal,
  output logic [1:0]  out_status
);
  import rau_pkg::*;

  job_t f_job, q_job;
  logic f_push, q_full, q_valid, q_pop;

  rau_front #(.WORD_WIDTH(WORD_WIDTH)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_action, .in_a_num, .in_a_den,
    .in_b_num, .in_b_den, .q_push(f_push), .q_full(q_full), .q_job(f_job)
  );

  rau_queue u_queue (
    .clk, .rst_n, .wr_en(f_push), .wr_job(f_job), .full(q_full),
    .rd_en(q_pop), .rd_valid(q_valid), .rd_job(q_job)
  );

  rau_back #(.WORD_WIDTH(WORD_WIDTH)) u_back (
    .clk, .rst_n, .q_valid, .q_job, .q_pop, .out_empty, .out_pop,
    .out_res_num, .out_res_den, .out_is_equal, .out_status
  );
endmodule
`default_nettype wire

// ===== bench/rau_checker.sv =====
// Checker for the rational arithmetic core: watches the input and result channels,
// predicts each result and compares it field by field. Depends on rau_pkg.
module rau_checker
  import rau_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_a_num,
  input  logic [31:0] in_a_den,
  input  logic [31:0] in_b_num,
  input  logic [31:0] in_b_den,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [31:0] out_res_num,
  input  logic [30:0] out_res_den,
  input  logic        out_is_equal,
  input  logic [1:0]  out_status,
  output int          fail_count,
  output int          pending,
  output int          checked,
  output logic        item_taken,
  output logic        result_taken
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] num;
    logic [30:0] den;
    logic        eq;
    logic [1:0]  st;
  } fraction_t;

  fraction_t expected_fractions[$];

  function automatic logic [63:0] mag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic fraction_t zero_frac(status_t st);
    fraction_t r;
    r.num = 0;
    r.den = 1;
    r.eq = 0;
    r.st = st;
    return r;
  endfunction

  function automatic fraction_t reduce_fraction(logic [2:0] act, logic signed [31:0] an,
                                                logic signed [31:0] ad, logic signed [31:0] bn,
                                                logic signed [31:0] bd);
    longint p, q;
    logic [63:0] mp, mq, nm, dm, x, y, t, lim;
    logic nneg, dneg, np, nq;
    fraction_t r;
    if (act > ACT_CMP) return zero_frac(ST_OK);
    if (ad == 0 || bd == 0) return zero_frac(ST_ZERO_DEN);
    if (act == ACT_CMP) begin
      r = zero_frac(ST_OK);
      r.eq = (longint'(an) * longint'(bd) == longint'(ad) * longint'(bn));
      return r;
    end
    dneg = (longint'(ad) * longint'(bd)) < 0;
    dm = mag(longint'(ad) * longint'(bd));
    case (action_t'(act))
      ACT_ADD, ACT_SUB: begin
        p = longint'(an) * longint'(bd);
        q = longint'(ad) * longint'(bn);
        if (act == ACT_SUB) q = -q;
        np = p < 0;
        nq = q < 0;
        mp = mag(p);
        mq = mag(q);
        if (np == nq) begin
          nneg = np;
          nm = mp + mq;
        end else if (mp >= mq) begin
          nneg = np;
          nm = mp - mq;
        end else begin
          nneg = nq;
          nm = mq - mp;
        end
      end
      ACT_MUL: begin
        p = longint'(an) * longint'(bn);
        nneg = p < 0;
        nm = mag(p);
      end
      default: begin
        p = longint'(an) * longint'(bd);
        nneg = p < 0;
        nm = mag(p);
        q = longint'(ad) * longint'(bn);
        dneg = q < 0;
        dm = mag(q);
      end
    endcase
    if (dm == 0) return zero_frac(ST_ZERO_DEN);
    if (nm == 0) return zero_frac(ST_OK);
    x = nm;
    y = dm;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    nm = nm / x;
    dm = dm / x;
    nneg = nneg != dneg;
    lim = 64'd1 << 31;
    if (dm > lim - 1 || nm > (nneg ? lim : lim - 1)) return zero_frac(ST_OVERFLOW);
    r.num = nneg ? 32'(-nm) : 32'(nm);
    r.den = 31'(dm);
    r.eq = 0;
    r.st = ST_OK;
    return r;
  endfunction

  assign item_taken = in_push && !in_full;
  assign result_taken = out_pop && !out_empty;
  assign pending = expected_fractions.size();

  always @(posedge clk) begin
    fraction_t e;
    if (!rst_n) begin
      fail_count <= 0;
      checked <= 0;
    end else begin
      if (item_taken)
        expected_fractions.push_back(reduce_fraction(in_action, in_a_num, in_a_den,
                                                     in_b_num, in_b_den));
      if (result_taken) begin
        if (expected_fractions.size() == 0) begin
          $display("%0t: result with none expected: %0d/%0d eq %0d st %0d", $time,
                   $signed(out_res_num), out_res_den, out_is_equal, out_status);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_fractions.pop_front();
          checked <= checked + 1;
          if (out_res_num !== e.num || out_res_den !== e.den ||
              out_is_equal !== e.eq || out_status !== e.st) begin
            $display("%0t: mismatch exp %0d/%0d eq %0d st %0d, got %0d/%0d eq %0d st %0d",
                     $time, $signed(e.num), e.den, e.eq, e.st, $signed(out_res_num),
                     out_res_den, out_is_equal, out_status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== bench/rational_arithmetic_unit_core_test.sv =====
// Stimulus and verdict for the rational arithmetic core.
// Depends on rau_pkg, rational_arithmetic_unit_core and rau_checker.
module rational_arithmetic_unit_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rau_pkg::*;

  localparam int IDLE_LIMIT = 60000;
  localparam int RANDOM_ITEMS = 1030;

  logic clk, rst_n;
  logic in_push, in_full, out_empty, out_pop;
  logic [2:0] in_action;
  logic [31:0] in_a_num, in_a_den, in_b_num, in_b_den, out_res_num;
  logic [30:0] out_res_den;
  logic out_is_equal;
  logic [1:0] out_status;
  int fail_count, pending, checked, sent, idle_cycles;
  logic item_taken, result_taken;
  bit no_idle;

  rational_arithmetic_unit_core dut (.*);
  rau_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (item_taken || result_taken || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [31:0] operand();
    case ($urandom_range(0, 3))
      0: return 32'($signed($urandom_range(0, 40)) - 20);
      1: return 32'($signed($urandom_range(0, 65535)) - 32768);
      2: return $urandom();
      default:
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          3: return 0;
          default: return 1;
        endcase
    endcase
  endfunction

  task automatic send(logic [2:0] act, logic [31:0] an, logic [31:0] ad,
                      logic [31:0] bn, logic [31:0] bd);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_push <= 0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1;
    in_action <= act;
    in_a_num <= an;
    in_a_den <= ad;
    in_b_num <= bn;
    in_b_den <= bd;
    do @(posedge clk); while (in_full);
    sent++;
  endtask

  initial begin
    int gap;
    out_pop = 0;
    @(posedge rst_n);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_pop <= 0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1;
      do @(posedge clk); while (out_empty);
    end
  end

  initial begin
    logic [31:0] mn, mx;
    mn = 32'h8000_0000;
    mx = 32'h7fff_ffff;
    rst_n = 0;
    in_push = 0;
    in_action = 0;
    in_a_num = 0;
    in_a_den = 1;
    in_b_num = 0;
    in_b_den = 1;
    sent = 0;
    no_idle = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send(ACT_ADD, 1, 2, 1, 3);
    send(ACT_SUB, 1, 2, 1, 2);
    send(ACT_MUL, -6, 4, 2, -9);
    send(ACT_DIV, 3, 7, -9, 14);
    send(ACT_CMP, 2, 4, -3, -6);
    send(ACT_CMP, 2, 4, 3, 5);
    send(ACT_ADD, 1, 0, 1, 1);
    send(ACT_CMP, 1, 1, 1, 0);
    send(ACT_DIV, 1, 1, 0, 5);
    send(ACT_MUL, 0, 7, 5, 3);
    send(ACT_ADD, mx, 1, mx, 1);
    send(ACT_SUB, mn, 1, 1, 1);
    send(ACT_MUL, mn, 1, 1, -1);
    send(ACT_MUL, mn, 1, 1, 1);
    send(ACT_DIV, mn, mn, mn, mx);
    send(ACT_ADD, mx, mn, mn, mx);
    send(ACT_MUL, mx, mx, mx, mx);
    send(ACT_DIV, 1, mx, 1, mn);
    send(3'd5, 3, 4, 5, 6);
    send(3'd6, 0, 0, 0, 0);
    send(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 150 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if (i == RANDOM_ITEMS / 2) begin
        in_push <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      send(3'($urandom_range(0, 9) > 8 ? $urandom_range(5, 7) : $urandom_range(0, 4)),
           operand(), operand(), operand(), operand());
    end
    in_push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d items (directed edges, all actions, random operands of mixed size);",
             sent);
    $display("checked %0d results against the predicted reduced fractions.", checked);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
